// ===== design/dccf_pkg.sv =====
package dccf_pkg;

  localparam int IN_W       = 21;
  localparam int OUT_W      = 32;
  localparam int CFW        = 30;
  localparam int BWW        = 24;
  localparam int DMW        = 32;
  localparam int LG_W       = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int DEF_MAX_LOG2_FFT    = 20;
  localparam int DEF_PHASE_FRAC_BITS = 32;
  localparam int MIN_LOG2_FFT        = 4;
  localparam int DEF_LOG2_FFT        = 10;

  localparam int K15_W = 35;
  localparam logic [K15_W-1:0] K15 = 35'd30517578125;

  localparam int DEN_SCALE_W = 8;
  localparam logic [DEN_SCALE_W-1:0] DEN_SCALE = 8'd241;

  localparam int ROOT_SHIFT    = 9;
  localparam int CORDIC_STAGES = 30;
  localparam int XW            = 44;
  localparam int ZW            = 34;

  localparam logic signed [XW-1:0] CORDIC_X0 = 44'sd667681663043;
  localparam logic signed [ZW-1:0] TURN_QTR  = 34'sd1073741824;
  localparam logic signed [ZW-1:0] TURN_HALF = 34'sd2147483648;

  localparam logic [31:0] ATAN_TURNS [CORDIC_STAGES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
    32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_FREQ   = 3'd0,
    REG_BANDWIDTH      = 3'd1,
    REG_LOWER_SIDEBAND = 3'd2,
    REG_DM             = 3'd3,
    REG_LOG2_FFT       = 3'd4
  } dccf_reg_t;

  typedef struct packed {
    logic [LG_W-1:0] lg;
    logic            neg;
    logic            zero;
  } dccf_side_t;

  typedef struct packed {
    logic [LG_W-1:0] lg;
    logic            flip;
  } dccf_rot_t;

endpackage

// ===== design/dccf_in_if.sv =====
interface dccf_in_if import dccf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] bin_index;

  modport source (output valid, output bin_index, input ready);
  modport sink (input valid, input bin_index, output ready);
endinterface

// ===== design/dccf_out_if.sv =====
interface dccf_out_if import dccf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] coeff_real;
  logic signed [OUT_W-1:0] coeff_imag;

  modport source (output valid, output coeff_real, output coeff_imag, input ready);
  modport sink (input valid, input coeff_real, input coeff_imag, output ready);
endinterface

// ===== design/dccf_mul.sv =====
module dccf_mul import dccf_pkg::*; #(
  parameter int WA = 32,
  parameter int WB = 32
) (
  input  logic            clk,
  input  logic            en,
  input  logic [WA-1:0]   a,
  input  logic [WB-1:0]   b,
  output logic [WA+WB-1:0] p
);

  localparam int NA  = (WA + 31) / 32;
  localparam int NB  = (WB + 31) / 32;
  localparam int ACW = (NA + NB) * 32;

  logic [NA*32-1:0]   ax;
  logic [NB*32-1:0]   bx;
  logic [63:0]        pp_r [NA][NB];
  logic [ACW-1:0]     acc_nxt;
  logic [WA+WB-1:0]   p_r;

  assign ax = (NA*32)'(a);
  assign bx = (NB*32)'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= ax[i*32 +: 32] * bx[j*32 +: 32];
        end
      end
    end
  end

  always_comb begin
    acc_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc_nxt = acc_nxt + (ACW'(pp_r[i][j]) << ((i + j) * 32));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= acc_nxt[WA+WB-1:0];
    end
  end

  assign p = p_r;

endmodule

// ===== design/dccf_div_cell.sv =====
module dccf_div_cell import dccf_pkg::*; #(
  parameter int NUMW = 8,
  parameter int DENW = 8,
  parameter int PF   = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_in,
  input  logic [NUMW-1:0] num_in,
  input  logic [DENW-1:0] den_in,
  input  logic [DENW-1:0] rem_in,
  input  logic [PF-1:0]   p_in,
  input  dccf_side_t      side_in,
  output logic            vld_out,
  output logic [NUMW-1:0] num_out,
  output logic [DENW-1:0] den_out,
  output logic [DENW-1:0] rem_out,
  output logic [PF-1:0]   p_out,
  output dccf_side_t      side_out
);

  logic [DENW:0]   trial;
  logic [DENW:0]   diff;
  logic            ge;
  logic [DENW-1:0] rem_nxt;
  logic            vld_r;
  logic [NUMW-1:0] num_r;
  logic [DENW-1:0] den_r;
  logic [DENW-1:0] rem_r;
  logic [PF-1:0]   p_r;
  dccf_side_t      side_r;

  always_comb begin
    trial   = {rem_in, num_in[NUMW-1]};
    diff    = trial - {1'b0, den_in};
    ge      = trial >= {1'b0, den_in};
    rem_nxt = ge ? diff[DENW-1:0] : trial[DENW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= num_in << 1;
      den_r  <= den_in;
      rem_r  <= rem_nxt;
      p_r    <= {p_in[PF-2:0], ge};
      side_r <= side_in;
    end
  end

  assign vld_out  = vld_r;
  assign num_out  = num_r;
  assign den_out  = den_r;
  assign rem_out  = rem_r;
  assign p_out    = p_r;
  assign side_out = side_r;

endmodule

// ===== design/dccf_cordic_cell.sv =====
module dccf_cordic_cell import dccf_pkg::*; #(
  parameter int K = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_in,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  input  dccf_rot_t            rot_in,
  output logic                 vld_out,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic signed [ZW-1:0] z_out,
  output dccf_rot_t            rot_out
);

  localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_TURNS[K]);

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [XW-1:0] x_nxt;
  logic signed [XW-1:0] y_nxt;
  logic signed [ZW-1:0] z_nxt;
  logic                 vld_r;
  logic signed [XW-1:0] x_r;
  logic signed [XW-1:0] y_r;
  logic signed [ZW-1:0] z_r;
  dccf_rot_t            rot_r;

  always_comb begin
    dx = y_in >>> K;
    dy = x_in >>> K;
    if (!z_in[ZW-1]) begin
      x_nxt = x_in - dx;
      y_nxt = y_in + dy;
      z_nxt = z_in - ANG;
    end else begin
      x_nxt = x_in + dx;
      y_nxt = y_in - dy;
      z_nxt = z_in + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      rot_r <= rot_in;
    end
  end

  assign vld_out = vld_r;
  assign x_out   = x_r;
  assign y_out   = y_r;
  assign z_out   = z_r;
  assign rot_out = rot_r;

endmodule

// ===== design/dedispersion_chirp_coefficient_top.sv =====
// Coherent dedispersion chirp coefficient generator.
// in_bus carries one FFT bin index per request; out_bus returns one complex
// coefficient exp(-j*2*pi*phi)/N per request, in request order, in units
// of 2^-31. Both channels use valid/ready; a request moves when both are high.
// Configuration must be written through cfg_wr_en/cfg_index/cfg_wr_data only
// while no request is in flight; the block itself does not enforce this.
// Throughput: one request per cycle while in_bus.ready is high. A request
// passes in order through the size/multiply front end, the restoring
// division row (one quotient bit per cell over the full numerator and the
// fraction bits), the phase sign register, the fold register, the 30-cell
// CORDIC row, the quadrant flip register and the output register.
// Reset (rst_n low, synchronous) restores the register defaults and empties
// the pipeline. When out_bus.ready is low, the finished coefficient waits in
// the output register; the next finished coefficient is still taken into a
// skid stage, after which in_bus.ready drops and the whole pipeline holds.
module dedispersion_chirp_coefficient_top import dccf_pkg::*; #(
  parameter int MAX_LOG2_FFT    = DEF_MAX_LOG2_FFT,
  parameter int PHASE_FRAC_BITS = DEF_PHASE_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dccf_in_if.sink               in_bus,
  dccf_out_if.source            out_bus,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

  localparam int ML   = MAX_LOG2_FFT;
  localparam int PF   = PHASE_FRAC_BITS;
  localparam int CW   = (ML + 1 > IN_W) ? ML + 1 : IN_W;
  localparam int DW   = ML + 2;
  localparam int D3W  = ML + 3;
  localparam int TW   = CFW + 3;
  localparam int AW   = BWW + ML + 3;
  localparam int MAW  = BWW + ML;
  localparam int MBW  = TW - 1 + ML;
  localparam int MCW  = MBW + 1;
  localparam int CSW  = MCW + 1;
  localparam int M1W  = 2 * MAW;
  localparam int M2W  = 2 * MBW;
  localparam int M3W  = DMW + K15_W;
  localparam int N1W  = M1W + M3W;
  localparam int D1W  = M2W + MCW;
  localparam int NUMW = N1W + ML;
  localparam int DENW = D1W + DEN_SCALE_W;
  localparam int NDIV = NUMW + PF;
  localparam int SHW  = LG_W + 1;

  logic [CFW-1:0]  cf_r;
  logic [BWW-1:0]  bw_r;
  logic            lsb_r;
  logic [DMW-1:0]  dm_r;
  logic [LG_W-1:0] lg_r;

  logic en;
  logic [7:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cf_r  <= '0;
      bw_r  <= BWW'(1);
      lsb_r <= 1'b0;
      dm_r  <= '0;
      lg_r  <= LG_W'(DEF_LOG2_FFT);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CHANNEL_FREQ:   cf_r  <= cfg_wr_data[CFW-1:0];
        REG_BANDWIDTH:      bw_r  <= cfg_wr_data[BWW-1:0];
        REG_LOWER_SIDEBAND: lsb_r <= cfg_wr_data[0];
        REG_DM:             dm_r  <= cfg_wr_data[DMW-1:0];
        REG_LOG2_FFT:       lg_r  <= cfg_wr_data[LG_W-1:0];
        default: ;
      endcase
    end
  end

  // size clamp, bin saturation, offsets
  logic [LG_W-1:0]      lg_c;
  logic [CW-1:0]        n_c;
  logic [CW-1:0]        bin_c;
  logic [CW-1:0]        i_c;
  logic [D3W-1:0]       d_c;
  logic [D3W-1:0]       dneg_c;
  logic [TW-1:0]        tp_c;
  logic [TW-1:0]        t_c;

  always_comb begin
    if (lg_r < LG_W'(MIN_LOG2_FFT)) begin
      lg_c = LG_W'(MIN_LOG2_FFT);
    end else if (lg_r > LG_W'(ML)) begin
      lg_c = LG_W'(ML);
    end else begin
      lg_c = lg_r;
    end
    n_c    = CW'(1) << lg_c;
    bin_c  = CW'(in_bus.bin_index);
    i_c    = (bin_c > n_c) ? n_c : bin_c;
    d_c    = (D3W'(i_c) << 1) - D3W'(n_c);
    dneg_c = D3W'(0) - d_c;
    tp_c   = TW'({cf_r, 1'b0});
    t_c    = lsb_r ? (tp_c - TW'(bw_r)) : (tp_c + TW'(bw_r));
  end

  logic [LG_W-1:0]        lg1_r;
  logic                   s1_r;
  logic signed [DW-1:0]   sd1_r;
  logic signed [TW-1:0]   t1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lg1_r <= lg_c;
      s1_r  <= lsb_r;
      sd1_r <= DW'(lsb_r ? dneg_c : d_c);
      t1_r  <= t_c;
    end
  end

  logic signed [AW-1:0]  bws;
  logic signed [AW-1:0]  sds;
  logic signed [AW-1:0]  a2_r;
  logic signed [CSW-1:0] b2_r;
  logic [LG_W-1:0]       lg2_r;
  logic                  s2_r;

  assign bws = AW'($signed({1'b0, bw_r}));
  assign sds = AW'(sd1_r);

  always_ff @(posedge clk) begin
    if (en) begin
      a2_r  <= bws * sds;
      b2_r  <= CSW'(t1_r) <<< lg1_r;
      lg2_r <= lg1_r;
      s2_r  <= s1_r;
    end
  end

  logic signed [CSW-1:0] c_c;
  logic signed [AW-1:0]  aabs_c;
  logic signed [CSW-1:0] babs_c;
  logic signed [CSW-1:0] cabs_c;
  logic [MAW-1:0]        ma3_r;
  logic [MBW-1:0]        mb3_r;
  logic [MCW-1:0]        mc3_r;
  dccf_side_t            sd3_r;

  always_comb begin
    c_c    = CSW'(a2_r) + b2_r;
    aabs_c = a2_r[AW-1] ? -a2_r : a2_r;
    babs_c = b2_r[CSW-1] ? -b2_r : b2_r;
    cabs_c = c_c[CSW-1] ? -c_c : c_c;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma3_r      <= MAW'(aabs_c);
      mb3_r      <= MBW'(babs_c);
      mc3_r      <= MCW'(cabs_c);
      sd3_r.lg   <= lg2_r;
      sd3_r.neg  <= s2_r ^ c_c[CSW-1];
      sd3_r.zero <= (b2_r == '0) || (c_c == '0);
    end
  end

  logic [M1W-1:0] m1;
  logic [M2W-1:0] m2;
  logic [M3W-1:0] m3;

  dccf_mul #(.WA(MAW), .WB(MAW)) u_mul_aa (
    .clk(clk), .en(en), .a(ma3_r), .b(ma3_r), .p(m1)
  );

  dccf_mul #(.WA(MBW), .WB(MBW)) u_mul_bb (
    .clk(clk), .en(en), .a(mb3_r), .b(mb3_r), .p(m2)
  );

  dccf_mul #(.WA(DMW), .WB(K15_W)) u_mul_dm (
    .clk(clk), .en(en), .a(dm_r), .b(K15), .p(m3)
  );

  logic [MCW-1:0] mc4_r;
  logic [MCW-1:0] mc5_r;
  dccf_side_t     sd4_r;
  dccf_side_t     sd5_r;
  dccf_side_t     sd6_r;
  dccf_side_t     sd7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mc4_r <= mc3_r;
      mc5_r <= mc4_r;
      sd4_r <= sd3_r;
      sd5_r <= sd4_r;
      sd6_r <= sd5_r;
      sd7_r <= sd6_r;
    end
  end

  logic [N1W-1:0] num1;
  logic [D1W-1:0] den1;

  dccf_mul #(.WA(M1W), .WB(M3W)) u_mul_num (
    .clk(clk), .en(en), .a(m1), .b(m3), .p(num1)
  );

  dccf_mul #(.WA(M2W), .WB(MCW)) u_mul_den (
    .clk(clk), .en(en), .a(m2), .b(mc5_r), .p(den1)
  );

  logic [NUMW-1:0] num8_r;
  logic [DENW-1:0] den8_r;
  dccf_side_t      sd8_r;

  always_ff @(posedge clk) begin
    if (en) begin
      num8_r <= NUMW'(num1) << sd7_r.lg;
      den8_r <= DENW'(den1) * DENW'(DEN_SCALE);
      sd8_r  <= sd7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[6:0], in_bus.valid};
    end
  end

  // restoring division row
  logic            dv    [NDIV+1];
  logic [NUMW-1:0] dnum  [NDIV+1];
  logic [DENW-1:0] dden  [NDIV+1];
  logic [DENW-1:0] drem  [NDIV+1];
  logic [PF-1:0]   dp    [NDIV+1];
  dccf_side_t      dside [NDIV+1];

  assign dv[0]    = vld_r[7];
  assign dnum[0]  = num8_r;
  assign dden[0]  = den8_r;
  assign drem[0]  = '0;
  assign dp[0]    = '0;
  assign dside[0] = sd8_r;

  for (genvar g = 0; g < NDIV; g++) begin : g_div
    dccf_div_cell #(.NUMW(NUMW), .DENW(DENW), .PF(PF)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_in(dv[g]), .num_in(dnum[g]), .den_in(dden[g]),
      .rem_in(drem[g]), .p_in(dp[g]), .side_in(dside[g]),
      .vld_out(dv[g+1]), .num_out(dnum[g+1]), .den_out(dden[g+1]),
      .rem_out(drem[g+1]), .p_out(dp[g+1]), .side_out(dside[g+1])
    );
  end

  // sign of the phase and fraction wrap
  logic            exact_c;
  logic [PF-1:0]   pfix_c;
  logic            ph_v_r;
  logic [PF-1:0]   ph_p_r;
  logic [LG_W-1:0] ph_lg_r;

  always_comb begin
    exact_c = (drem[NDIV] == '0);
    if (dside[NDIV].zero) begin
      pfix_c = '0;
    end else if (dside[NDIV].neg) begin
      pfix_c = ~dp[NDIV] + PF'(exact_c);
    end else begin
      pfix_c = dp[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_v_r <= 1'b0;
    end else if (en) begin
      ph_v_r <= dv[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph_p_r  <= pfix_c;
      ph_lg_r <= dside[NDIV].lg;
    end
  end

  // fold into +-1/4 turn
  logic [31:0]          r32_c;
  logic signed [ZW-1:0] sang_c;
  logic signed [ZW-1:0] z0_c;
  logic                 flip_c;
  logic                 fv_r;
  logic signed [ZW-1:0] fz_r;
  dccf_rot_t            frot_r;

  always_comb begin
    r32_c  = 32'((96'(ph_p_r) << 32) >> PF);
    sang_c = ZW'($signed(r32_c));
    if (sang_c > TURN_QTR) begin
      z0_c   = sang_c - TURN_HALF;
      flip_c = 1'b1;
    end else if (sang_c < -TURN_QTR) begin
      z0_c   = sang_c + TURN_HALF;
      flip_c = 1'b1;
    end else begin
      z0_c   = sang_c;
      flip_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (en) begin
      fv_r <= ph_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fz_r        <= z0_c;
      frot_r.lg   <= ph_lg_r;
      frot_r.flip <= flip_c;
    end
  end

  // CORDIC row
  logic                 cv   [CORDIC_STAGES+1];
  logic signed [XW-1:0] cx   [CORDIC_STAGES+1];
  logic signed [XW-1:0] cy   [CORDIC_STAGES+1];
  logic signed [ZW-1:0] cz   [CORDIC_STAGES+1];
  dccf_rot_t            crot [CORDIC_STAGES+1];

  assign cv[0]   = fv_r;
  assign cx[0]   = CORDIC_X0;
  assign cy[0]   = '0;
  assign cz[0]   = fz_r;
  assign crot[0] = frot_r;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
    dccf_cordic_cell #(.K(k)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .vld_in(cv[k]), .x_in(cx[k]), .y_in(cy[k]), .z_in(cz[k]), .rot_in(crot[k]),
      .vld_out(cv[k+1]), .x_out(cx[k+1]), .y_out(cy[k+1]), .z_out(cz[k+1]),
      .rot_out(crot[k+1])
    );
  end

  logic                 pa_v_r;
  logic signed [XW-1:0] pa_x_r;
  logic signed [XW-1:0] pa_y_r;
  logic [LG_W-1:0]      pa_lg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_v_r <= 1'b0;
    end else if (en) begin
      pa_v_r <= cv[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_x_r  <= crot[CORDIC_STAGES].flip ? -cx[CORDIC_STAGES] : cx[CORDIC_STAGES];
      pa_y_r  <= crot[CORDIC_STAGES].flip ? cy[CORDIC_STAGES] : -cy[CORDIC_STAGES];
      pa_lg_r <= crot[CORDIC_STAGES].lg;
    end
  end

  // scale by 1/N with rounding
  logic [SHW-1:0]       sh_c;
  logic signed [XW:0]   half_c;
  logic signed [XW:0]   rx_c;
  logic signed [XW:0]   ry_c;
  logic signed [XW:0]   ro_c;
  logic signed [XW:0]   io_c;

  always_comb begin
    sh_c   = SHW'(ROOT_SHIFT) + SHW'(pa_lg_r);
    half_c = (XW+1)'(1) << (sh_c - SHW'(1));
    rx_c   = (XW+1)'(pa_x_r) + half_c;
    ry_c   = (XW+1)'(pa_y_r) + half_c;
    ro_c   = rx_c >>> sh_c;
    io_c   = ry_c >>> sh_c;
  end

  // output register with skid stage
  logic                    ov_r;
  logic                    skv_r;
  logic signed [OUT_W-1:0] ore_r;
  logic signed [OUT_W-1:0] oim_r;
  logic signed [OUT_W-1:0] skre_r;
  logic signed [OUT_W-1:0] skim_r;

  assign en = !skv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      skv_r <= 1'b0;
    end else if (en && pa_v_r) begin
      if (ov_r && !out_bus.ready) begin
        skv_r <= 1'b1;
      end else begin
        ov_r <= 1'b1;
      end
    end else if (out_bus.ready) begin
      ov_r  <= skv_r;
      skv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && pa_v_r) begin
      if (ov_r && !out_bus.ready) begin
        skre_r <= ro_c[OUT_W-1:0];
        skim_r <= io_c[OUT_W-1:0];
      end else begin
        ore_r <= ro_c[OUT_W-1:0];
        oim_r <= io_c[OUT_W-1:0];
      end
    end else if (out_bus.ready && skv_r) begin
      ore_r <= skre_r;
      oim_r <= skim_r;
    end
  end

  assign in_bus.ready       = en;
  assign out_bus.valid      = ov_r;
  assign out_bus.coeff_real = ore_r;
  assign out_bus.coeff_imag = oim_r;

endmodule

// ===== dv/dccf_chirp_checker.sv =====
`timescale 1ns / 100ps

module dccf_chirp_checker import dccf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [IN_W-1:0]         in_bin_index,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [OUT_W-1:0] out_coeff_real,
  input  logic signed [OUT_W-1:0] out_coeff_imag,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wr_data,
  output int                      mismatch_count,
  output int                      coeff_pending
);

  localparam int PFB = DEF_PHASE_FRAC_BITS;

  typedef struct packed {
    logic [OUT_W-1:0] re;
    logic [OUT_W-1:0] im;
  } coeff_t;

  coeff_t          coeff_q[$];
  logic [CFW-1:0]  cf_q;
  logic [BWW-1:0]  bw_q;
  logic            lsb_q;
  logic [DMW-1:0]  dm_q;
  logic [LG_W-1:0] lg_q;

  function automatic coeff_t chirp_coeff(input logic [IN_W-1:0] bin);
    int unsigned lg;
    longint n, i, s, a, b, c, sang, x, y, z, dx, dy, at, ro, io, half;
    logic [63:0] ma, mb, mc, p, r32;
    logic [255:0] num, den, rem, sh_rem;
    logic neg, exact, flip;
    int unsigned sh;
    coeff_t res;
    lg = lg_q;
    if (lg < MIN_LOG2_FFT) lg = MIN_LOG2_FFT;
    if (lg > DEF_MAX_LOG2_FFT) lg = DEF_MAX_LOG2_FFT;
    n = longint'(1) << lg;
    i = longint'(bin);
    if (i > n) i = n;
    s = lsb_q ? -1 : 1;
    a = s * longint'(bw_q) * (2 * i - n);
    b = n * (2 * longint'(cf_q) + s * longint'(bw_q));
    c = a + b;
    p = '0;
    if (b != 0 && c != 0) begin
      neg = (s < 0) != (c < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      mc = (c < 0) ? -c : c;
      num = 256'(dm_q) * 256'(ma) * 256'(ma) * 256'(n) * 256'(K15);
      den = 256'(DEN_SCALE) * 256'(mb) * 256'(mb) * 256'(mc);
      rem = num % den;
      if (rem != 0) begin
        sh_rem = rem << PFB;
        p = 64'(sh_rem / den);
        exact = (sh_rem % den) == 0;
        if (neg) p = (64'd1 << PFB) - p - (exact ? 64'd0 : 64'd1);
        p = p & ((64'd1 << PFB) - 64'd1);
      end
    end
    r32 = p >> (PFB - 32);
    sang = (r32 < 64'h8000_0000) ? longint'(r32) : longint'(r32) - 64'sh1_0000_0000;
    flip = 1'b0;
    if (sang > longint'(TURN_QTR)) begin
      sang = sang - longint'(TURN_HALF);
      flip = 1'b1;
    end else if (sang < -longint'(TURN_QTR)) begin
      sang = sang + longint'(TURN_HALF);
      flip = 1'b1;
    end
    x = longint'(CORDIC_X0);
    y = 0;
    z = sang;
    for (int k = 0; k < CORDIC_STAGES; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      at = longint'(ATAN_TURNS[k]);
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - at;
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + at;
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    sh = ROOT_SHIFT + lg;
    half = longint'(1) <<< (sh - 1);
    ro = (x + half) >>> sh;
    io = (-y + half) >>> sh;
    res.re = ro[OUT_W-1:0];
    res.im = io[OUT_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    coeff_t got, want;
    if (!rst_n) begin
      cf_q  <= '0;
      bw_q  <= BWW'(1);
      lsb_q <= 1'b0;
      dm_q  <= '0;
      lg_q  <= LG_W'(DEF_LOG2_FFT);
      coeff_q.delete();
      mismatch_count <= 0;
      coeff_pending  <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (dccf_reg_t'(cfg_index))
          REG_CHANNEL_FREQ:   cf_q  <= cfg_wr_data[CFW-1:0];
          REG_BANDWIDTH:      bw_q  <= cfg_wr_data[BWW-1:0];
          REG_LOWER_SIDEBAND: lsb_q <= cfg_wr_data[0];
          REG_DM:             dm_q  <= cfg_wr_data[DMW-1:0];
          REG_LOG2_FFT:       lg_q  <= cfg_wr_data[LG_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) coeff_q.push_back(chirp_coeff(in_bin_index));
      if (out_valid && out_ready) begin
        got.re = out_coeff_real;
        got.im = out_coeff_imag;
        if (coeff_q.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("unexpected coefficient re=%h im=%h", got.re, got.im);
        end else begin
          want = coeff_q.pop_front();
          if (got !== want) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("coefficient mismatch: expected re=%h im=%h, got re=%h im=%h",
                       want.re, want.im, got.re, got.im);
          end
        end
      end
      coeff_pending <= coeff_q.size();
    end
  end

endmodule

// ===== dv/tb_dedispersion_chirp_coefficient_top.sv =====
`timescale 1ns / 100ps

module tb_dedispersion_chirp_coefficient_top;
  import dccf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wr_data;
  logic                  quiet;
  int                    out_hold;
  int                    cycles;
  int                    mismatch_count;
  int                    coeff_pending;

  dccf_in_if  in_bus ();
  dccf_out_if out_bus ();

  dedispersion_chirp_coefficient_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .out_bus    (out_bus),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data)
  );

  dccf_chirp_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_bus.valid),
    .in_ready      (in_bus.ready),
    .in_bin_index  (in_bus.bin_index),
    .out_valid     (out_bus.valid),
    .out_ready     (out_bus.ready),
    .out_coeff_real(out_bus.coeff_real),
    .out_coeff_imag(out_bus.coeff_imag),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wr_data   (cfg_wr_data),
    .mismatch_count(mismatch_count),
    .coeff_pending (coeff_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // hold ready low for a drawn number of cycles after each result
  always @(posedge clk) begin
    int d;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      out_hold      <= 0;
    end else if (out_bus.ready && out_bus.valid) begin
      d = quiet ? 0 : $urandom_range(0, 8);
      if (d != 0) begin
        out_bus.ready <= 1'b0;
        out_hold      <= d - 1;
      end
    end else if (!out_bus.ready) begin
      if (out_hold == 0) out_bus.ready <= 1'b1;
      else out_hold <= out_hold - 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= d;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] cf, input logic [31:0] bw, input logic lsb,
                            input logic [31:0] dm, input logic [31:0] lg);
    write_reg(REG_CHANNEL_FREQ, cf);
    write_reg(REG_BANDWIDTH, bw);
    write_reg(REG_LOWER_SIDEBAND, {31'd0, lsb});
    write_reg(REG_DM, dm);
    write_reg(REG_LOG2_FFT, lg);
  endtask

  task automatic send_bin(input logic [IN_W-1:0] bin);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.bin_index <= bin;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (coeff_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    logic [31:0] cf, bw, dm, lg;
    int n, sel;
    quiet            = 1'b0;
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_index        = '0;
    cfg_wr_data      = '0;
    in_bus.valid     = 1'b0;
    in_bus.bin_index = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_bin(21'd0);
    send_bin(21'd1024);
    send_bin(21'h1F_FFFF);
    drain();

    // f + f0 = 0 at bin zero
    set_config(32'd0, 32'd1000, 1'b0, 32'h0001_0000, 32'd4);
    send_bin(21'd0);
    send_bin(21'd8);
    send_bin(21'd16);
    drain();

    // f0 = 0 on the lower sideband
    set_config(32'd500, 32'd1000, 1'b1, 32'h0001_0000, 32'd4);
    send_bin(21'd0);
    send_bin(21'd5);
    send_bin(21'd16);
    drain();

    set_config(32'h3FFF_FFFF, 32'hFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'd20);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_bin(21'd0);
    send_bin(21'd524288);
    send_bin(21'd1048576);
    send_bin(21'h1F_FFFF);
    drain();

    set_config(32'd1_400_000, 32'd0, 1'b0, 32'hFFFF_FFFF, 32'd31);
    send_bin(21'd0);
    send_bin(21'd777);
    drain();
    write_reg(REG_BANDWIDTH, 32'd16_000);
    send_bin(21'd3);
    send_bin(21'd12345);
    drain();

    set_config(32'd300_000, 32'd32_000, 1'b0, 32'h0123_4567, 32'd0);
    send_bin(21'd0);
    send_bin(21'd9);
    send_bin(21'd16);
    send_bin(21'd17);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      quiet = (ph % 4 == 3);
      cf = $urandom_range(0, 32'h3FFF_FFFF);
      bw = $urandom_range(1, 32'hFF_FFFF);
      dm = $urandom();
      sel = $urandom_range(0, 9);
      if (sel < 6) lg = $urandom_range(4, 12);
      else if (sel < 8) lg = $urandom_range(0, 31);
      else lg = 20;
      if (ph == 0) begin
        cf = 32'h3FFF_FFFF;
        bw = 32'hFF_FFFF;
        dm = 32'hFFFF_FFFF;
        lg = 20;
      end else if (ph == 1) begin
        cf = 32'd0;
        bw = 32'd1;
        dm = 32'd1;
        lg = 4;
      end else if (ph % 3 == 2) begin
        cf = $urandom_range(10_000, 2_000_000);
        bw = $urandom_range(1_000, 64_000);
        dm = $urandom_range(0, 32'h00FF_FFFF);
      end
      set_config(cf, bw, 1'($urandom_range(0, 1)), dm, lg);
      n = 1 << ((lg < 4) ? 4 : (lg > 20) ? 20 : lg);
      for (int k = 0; k < 128; k++) begin
        if ($urandom_range(0, 9) == 0) send_bin(21'($urandom()));
        else send_bin(21'($urandom_range(0, n)));
      end
      drain();
    end

    quiet = 1'b0;
    repeat (260) @(posedge clk);
    if (mismatch_count == 0 && coeff_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dccf_pkg.sv
design/dccf_in_if.sv
design/dccf_out_if.sv
design/dccf_mul.sv
design/dccf_div_cell.sv
design/dccf_cordic_cell.sv
design/dedispersion_chirp_coefficient_top.sv
dv/dccf_chirp_checker.sv
dv/tb_dedispersion_chirp_coefficient_top.sv
